FILE: sv/teb_pkg.sv
// teb_pkg: shared types, codes and defaults for the timed event buffer
// used by teb_cell and timed_event_buffer; no dependencies
package teb_pkg;

  // default sizes
  localparam int DEPTH_DEF      = 32;
  localparam int ID_WIDTH_DEF   = 8;
  localparam int TIME_WIDTH_DEF = 32;

  // fixed field widths
  localparam int CAP_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int KIND_W     = 2;

  // register reset values
  localparam logic [CAP_W-1:0]      CAP_RST  = 6'd20;
  localparam logic [CFG_DATA_W-1:0] INTV_RST = 32'd100;
  localparam logic [CFG_DATA_W-1:0] WIN_RST  = 32'd500;

  // item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_EVENT = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPACITY = 2'd0,
    CFG_INTERVAL = 2'd1,
    CFG_WINDOW   = 2'd2
  } cfg_idx_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_APPEND,
    ST_TICK,
    ST_FINISH
  } state_t;

  // per-cycle control shared by every cell of the row
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

FILE: sv/teb_cell.sv
// teb_cell: one entry of the buffer row; takes its right neighbor on a shift
// or the pushed entry when the write position names this cell
// depends on teb_pkg
module teb_cell #(
  parameter int IDX        = 0,
  parameter int IDX_W      = 5,
  parameter int ID_WIDTH   = teb_pkg::ID_WIDTH_DEF,
  parameter int TIME_WIDTH = teb_pkg::TIME_WIDTH_DEF
) (
  input  logic                  clk,
  input  teb_pkg::cell_ctl_t    ctl,
  input  logic [IDX_W-1:0]      wpos,
  input  logic [ID_WIDTH-1:0]   nb_id,
  input  logic                  nb_act,
  input  logic [TIME_WIDTH-1:0] nb_start,
  input  logic [TIME_WIDTH-1:0] nb_end,
  input  logic [ID_WIDTH-1:0]   ld_id,
  input  logic                  ld_act,
  input  logic [TIME_WIDTH-1:0] ld_start,
  input  logic [TIME_WIDTH-1:0] ld_end,
  output logic [ID_WIDTH-1:0]   q_id,
  output logic                  q_act,
  output logic [TIME_WIDTH-1:0] q_start,
  output logic [TIME_WIDTH-1:0] q_end
);

  logic [ID_WIDTH-1:0]   id_r;
  logic                  act_r;
  logic [TIME_WIDTH-1:0] start_r;
  logic [TIME_WIDTH-1:0] end_r;
  logic                  hit;

  assign hit = ctl.load && (wpos == IDX_W'(IDX));

  // entry storage: push wins over shift
  always_ff @(posedge clk) begin
    if (hit) begin
      id_r    <= ld_id;
      act_r   <= ld_act;
      start_r <= ld_start;
      end_r   <= ld_end;
    end else if (ctl.shift) begin
      id_r    <= nb_id;
      act_r   <= nb_act;
      start_r <= nb_start;
      end_r   <= nb_end;
    end
  end

  assign q_id    = id_r;
  assign q_act   = act_r;
  assign q_start = start_r;
  assign q_end   = end_r;

endmodule

FILE: sv/timed_event_buffer.sv
// timed_event_buffer: ordered buffer of timestamped events in a row of cells.
// an event scans then appends, an update scans then applies, an eviction scans,
// applies and appends, a tick is one pass, clear or unknown kind just finishes;
// one item at a time, the next taken after the result loads; passes rotate one entry a cycle.
// reset: occupancy 0, registers to capacity 20, interval 100, window 500;
// entry contents are not cleared and are never read above the occupancy.
module timed_event_buffer #(
  parameter int DEPTH      = teb_pkg::DEPTH_DEF,
  parameter int ID_WIDTH   = teb_pkg::ID_WIDTH_DEF,
  parameter int TIME_WIDTH = teb_pkg::TIME_WIDTH_DEF,
  localparam int CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [teb_pkg::KIND_W-1:0]       in_kind,
  input  logic [ID_WIDTH-1:0]              in_event_id,
  input  logic                             in_active_in,
  input  logic [TIME_WIDTH-1:0]            in_now,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_updated,
  output logic                             out_inserted,
  output logic                             out_evicted,
  output logic [ID_WIDTH-1:0]              out_evicted_id,
  output logic [CNT_W-1:0]                 out_removed_count,
  output logic [CNT_W-1:0]                 out_occupancy,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [teb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [teb_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CW    = ((CNT_W > teb_pkg::CAP_W) ? CNT_W : teb_pkg::CAP_W) + 1;
  localparam int CMP_W = (TIME_WIDTH > teb_pkg::CFG_DATA_W) ? TIME_WIDTH
                                                             : teb_pkg::CFG_DATA_W;

  // configuration registers
  logic [teb_pkg::CAP_W-1:0]      cap_r;
  logic [teb_pkg::CFG_DATA_W-1:0] intv_r;
  logic [teb_pkg::CFG_DATA_W-1:0] win_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= teb_pkg::CAP_RST;
      intv_r <= teb_pkg::INTV_RST;
      win_r  <= teb_pkg::WIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (teb_pkg::cfg_idx_t'(cfg_index))
        teb_pkg::CFG_CAPACITY: cap_r  <= cfg_data[teb_pkg::CAP_W-1:0];
        teb_pkg::CFG_INTERVAL: intv_r <= cfg_data;
        teb_pkg::CFG_WINDOW:   win_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // cell row
  teb_pkg::cell_ctl_t    ctl;
  logic [IDX_W-1:0]      wpos;
  logic [ID_WIDTH-1:0]   ld_id;
  logic                  ld_act;
  logic [TIME_WIDTH-1:0] ld_start;
  logic [TIME_WIDTH-1:0] ld_end;
  logic [ID_WIDTH-1:0]   c_id    [DEPTH];
  logic                  c_act   [DEPTH];
  logic [TIME_WIDTH-1:0] c_start [DEPTH];
  logic [TIME_WIDTH-1:0] c_end   [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_last
      teb_cell #(.IDX(i), .IDX_W(IDX_W), .ID_WIDTH(ID_WIDTH), .TIME_WIDTH(TIME_WIDTH)) u_cell (
        .clk(clk), .ctl(ctl), .wpos(wpos),
        .nb_id(ld_id), .nb_act(ld_act), .nb_start(ld_start), .nb_end(ld_end),
        .ld_id(ld_id), .ld_act(ld_act), .ld_start(ld_start), .ld_end(ld_end),
        .q_id(c_id[i]), .q_act(c_act[i]), .q_start(c_start[i]), .q_end(c_end[i])
      );
    end else begin : g_mid
      teb_cell #(.IDX(i), .IDX_W(IDX_W), .ID_WIDTH(ID_WIDTH), .TIME_WIDTH(TIME_WIDTH)) u_cell (
        .clk(clk), .ctl(ctl), .wpos(wpos),
        .nb_id(c_id[i+1]), .nb_act(c_act[i+1]),
        .nb_start(c_start[i+1]), .nb_end(c_end[i+1]),
        .ld_id(ld_id), .ld_act(ld_act), .ld_start(ld_start), .ld_end(ld_end),
        .q_id(c_id[i]), .q_act(c_act[i]), .q_start(c_start[i]), .q_end(c_end[i])
      );
    end
  end

  // sequencer registers
  teb_pkg::state_t       state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CNT_W-1:0]      len_r, len_nxt;
  logic [CNT_W-1:0]      step_r, step_nxt;
  logic [IDX_W-1:0]      hit_r, hit_nxt;
  logic [IDX_W-1:0]      victim_r, victim_nxt;
  logic                  found_r, found_nxt;
  logic                  hit_act_r, hit_act_nxt;
  logic                  vfound_r, vfound_nxt;
  logic                  upd_r, upd_nxt;
  logic                  ins_r, ins_nxt;
  logic                  ev_r, ev_nxt;
  logic [ID_WIDTH-1:0]   evid_r, evid_nxt;
  logic [CNT_W-1:0]      removed_r, removed_nxt;
  logic [ID_WIDTH-1:0]   id_r, id_nxt;
  logic                  act_r, act_nxt;
  logic [TIME_WIDTH-1:0] now_r, now_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_load;

  // derived values
  logic [IDX_W-1:0]      idx;
  logic                  last;
  logic [CW-1:0]         eff_cap;
  logic                  at_cap;
  logic [TIME_WIDTH-1:0] since_end;
  logic [TIME_WIDTH-1:0] since_start;
  logic                  aged;
  logic                  expire;

  assign idx  = step_r[IDX_W-1:0];
  assign last = (step_r == cnt_r - CNT_W'(1));
  assign eff_cap = ((cap_r == '0) || (CW'(cap_r) > CW'(DEPTH))) ? CW'(DEPTH) : CW'(cap_r);
  assign at_cap  = (CW'(cnt_r) >= eff_cap);
  assign since_end   = now_r - c_end[0];
  assign since_start = now_r - c_start[0];
  assign aged   = c_act[0] && !(CMP_W'(since_end) > CMP_W'(intv_r));
  assign expire = !aged && (CMP_W'(since_start) > CMP_W'(win_r));

  assign in_stall = (state_r != teb_pkg::ST_IDLE);

  // next state and row control
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    len_nxt     = len_r;
    step_nxt    = step_r;
    hit_nxt     = hit_r;
    victim_nxt  = victim_r;
    found_nxt   = found_r;
    hit_act_nxt = hit_act_r;
    vfound_nxt  = vfound_r;
    upd_nxt     = upd_r;
    ins_nxt     = ins_r;
    ev_nxt      = ev_r;
    evid_nxt    = evid_r;
    removed_nxt = removed_r;
    id_nxt      = id_r;
    act_nxt     = act_r;
    now_nxt     = now_r;
    out_load    = 1'b0;
    ctl.shift   = 1'b0;
    ctl.load    = 1'b0;
    wpos        = IDX_W'(len_r - CNT_W'(1));
    ld_id       = c_id[0];
    ld_act      = c_act[0];
    ld_start    = c_start[0];
    ld_end      = c_end[0];

    case (state_r)
      teb_pkg::ST_IDLE: begin
        if (in_valid) begin
          id_nxt      = in_event_id;
          act_nxt     = in_active_in;
          now_nxt     = in_now;
          len_nxt     = cnt_r;
          step_nxt    = '0;
          hit_nxt     = '0;
          victim_nxt  = '0;
          found_nxt   = 1'b0;
          hit_act_nxt = 1'b0;
          vfound_nxt  = 1'b0;
          upd_nxt     = 1'b0;
          ins_nxt     = 1'b0;
          ev_nxt      = 1'b0;
          evid_nxt    = '0;
          removed_nxt = '0;
          case (teb_pkg::kind_t'(in_kind))
            teb_pkg::KIND_EVENT:
              state_nxt = (cnt_r == '0) ? teb_pkg::ST_APPEND : teb_pkg::ST_SCAN;
            teb_pkg::KIND_TICK:
              state_nxt = (cnt_r == '0) ? teb_pkg::ST_FINISH : teb_pkg::ST_TICK;
            teb_pkg::KIND_CLEAR: begin
              cnt_nxt   = '0;
              state_nxt = teb_pkg::ST_FINISH;
            end
            default: state_nxt = teb_pkg::ST_FINISH;
          endcase
        end
      end

      // find newest match and earliest inactive entry, row unchanged
      teb_pkg::ST_SCAN: begin
        ctl.shift = 1'b1;
        ctl.load  = 1'b1;
        if (c_id[0] == id_r) begin
          found_nxt   = 1'b1;
          hit_nxt     = idx;
          hit_act_nxt = c_act[0];
        end
        if (!c_act[0] && !vfound_r) begin
          vfound_nxt = 1'b1;
          victim_nxt = idx;
        end
        step_nxt = step_r + CNT_W'(1);
        if (last) begin
          step_nxt = '0;
          if (found_nxt && hit_act_nxt) begin
            upd_nxt   = 1'b1;
            state_nxt = teb_pkg::ST_APPLY;
          end else if (at_cap) begin
            ev_nxt    = 1'b1;
            state_nxt = teb_pkg::ST_APPLY;
          end else begin
            state_nxt = teb_pkg::ST_APPEND;
          end
        end
      end

      // update the hit entry or drop the victim
      teb_pkg::ST_APPLY: begin
        ctl.shift = 1'b1;
        ctl.load  = 1'b1;
        if (upd_r && (idx == hit_r)) begin
          ld_act = act_r;
          ld_end = now_r;
        end else if (ev_r && (idx == victim_r)) begin
          ctl.load = 1'b0;
          len_nxt  = len_r - CNT_W'(1);
          evid_nxt = c_id[0];
        end
        step_nxt = step_r + CNT_W'(1);
        if (last) begin
          cnt_nxt   = len_nxt;
          state_nxt = upd_r ? teb_pkg::ST_FINISH : teb_pkg::ST_APPEND;
        end
      end

      // new entry at the tail
      teb_pkg::ST_APPEND: begin
        if (CW'(cnt_r) < CW'(DEPTH)) begin
          ctl.load = 1'b1;
          wpos     = IDX_W'(cnt_r);
          ld_id    = id_r;
          ld_act   = act_r;
          ld_start = now_r;
          ld_end   = now_r;
          cnt_nxt  = cnt_r + CNT_W'(1);
          ins_nxt  = 1'b1;
        end
        state_nxt = teb_pkg::ST_FINISH;
      end

      // age, expire and compact
      teb_pkg::ST_TICK: begin
        ctl.shift = 1'b1;
        ld_act    = aged;
        if (expire) begin
          len_nxt     = len_r - CNT_W'(1);
          removed_nxt = removed_r + CNT_W'(1);
        end else begin
          ctl.load = 1'b1;
        end
        step_nxt = step_r + CNT_W'(1);
        if (last) begin
          cnt_nxt   = len_nxt;
          state_nxt = teb_pkg::ST_FINISH;
        end
      end

      teb_pkg::ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = teb_pkg::ST_IDLE;
        end
      end

      default: state_nxt = teb_pkg::ST_IDLE;
    endcase
  end

  // output handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= teb_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    len_r     <= len_nxt;
    step_r    <= step_nxt;
    hit_r     <= hit_nxt;
    victim_r  <= victim_nxt;
    found_r   <= found_nxt;
    hit_act_r <= hit_act_nxt;
    vfound_r  <= vfound_nxt;
    upd_r     <= upd_nxt;
    ins_r     <= ins_nxt;
    ev_r      <= ev_nxt;
    evid_r    <= evid_nxt;
    removed_r <= removed_nxt;
    id_r      <= id_nxt;
    act_r     <= act_nxt;
    now_r     <= now_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_updated       <= upd_r;
      out_inserted      <= ins_r;
      out_evicted       <= ev_r;
      out_evicted_id    <= evid_r;
      out_removed_count <= removed_r;
      out_occupancy     <= cnt_r;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(cnt_r) <= CW'(DEPTH))
    else $error("occupancy above depth");
  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == teb_pkg::ST_FINISH))
    else $error("result raised outside finish");
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == teb_pkg::ST_TICK || state_r == teb_pkg::ST_APPLY) |-> len_r <= cnt_r)
    else $error("queue length above occupancy during pass");
`endif

endmodule

FILE: bench/tb_top.sv
// tb_top: self-checking bench for timed_event_buffer, with an event buffer predictor
// depends on teb_pkg and timed_event_buffer; drives items, registers and random stalls
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 32;
  localparam int N_RANDOM = 1900;
  localparam int IDLE_LIMIT = 20000;

  // result record
  typedef struct packed {
    logic       updated;
    logic       inserted;
    logic       evicted;
    logic [7:0] evicted_id;
    logic [5:0] removed_count;
    logic [5:0] occupancy;
  } outcome_t;

  // directed row: item plus optional typed-in outcome
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  event_id;
    logic        active_in;
    logic [31:0] now;
    logic        typed;
    outcome_t    want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_kind = '0;
  logic [7:0] in_event_id = '0;
  logic in_active_in = 1'b0;
  logic [31:0] in_now = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_updated, out_inserted, out_evicted;
  logic [7:0] out_evicted_id;
  logic [5:0] out_removed_count, out_occupancy;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  timed_event_buffer dut (.*);

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [7:0]  buf_id[DEPTH];
  logic        buf_act[DEPTH];
  logic [31:0] buf_start[DEPTH];
  logic [31:0] buf_end[DEPTH];
  int          buf_count;
  logic [5:0]  reg_cap;
  logic [31:0] reg_intv, reg_win;

  outcome_t pending_outcomes[$];
  int errors = 0;
  int n_items = 0, n_results = 0, n_evictions = 0, n_removed = 0;
  int in_idle_pct = 0, out_idle_pct = 0;
  int idle_cycles = 0;

  // mismatch report
  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("error at result %0d: %s got %0d want %0d", n_results, what, got, want);
  endtask

  function automatic void drop_entry(input int idx);
    for (int i = idx; i + 1 < buf_count; i++) begin
      buf_id[i] = buf_id[i+1];
      buf_act[i] = buf_act[i+1];
      buf_start[i] = buf_start[i+1];
      buf_end[i] = buf_end[i+1];
    end
    buf_count--;
  endfunction

  // compute the outcome of one item and advance the buffer
  function automatic outcome_t buffer_outcome(input logic [1:0] kind, input logic [7:0] id,
                                              input logic act, input logic [31:0] now);
    outcome_t o;
    int hit, victim, keep, cap;
    o = '0;
    if (kind == teb_pkg::KIND_EVENT) begin
      hit = -1;
      for (int i = buf_count - 1; i >= 0; i--) begin
        if (hit < 0 && buf_id[i] == id) hit = i;
      end
      if (hit >= 0 && buf_act[hit]) begin
        buf_act[hit] = act;
        buf_end[hit] = now;
        o.updated = 1'b1;
      end else begin
        cap = (reg_cap == 0 || reg_cap > DEPTH) ? DEPTH : int'(reg_cap);
        if (buf_count >= cap && buf_count > 0) begin
          victim = -1;
          for (int i = 0; i < buf_count; i++) begin
            if (victim < 0 && !buf_act[i]) victim = i;
          end
          if (victim < 0) victim = 0;
          o.evicted = 1'b1;
          o.evicted_id = buf_id[victim];
          drop_entry(victim);
        end
        if (buf_count < DEPTH) begin
          buf_id[buf_count] = id;
          buf_act[buf_count] = act;
          buf_start[buf_count] = now;
          buf_end[buf_count] = now;
          buf_count++;
          o.inserted = 1'b1;
        end
      end
    end else if (kind == teb_pkg::KIND_TICK) begin
      keep = 0;
      for (int i = 0; i < buf_count; i++) begin
        if (buf_act[i] && (now - buf_end[i]) > reg_intv) buf_act[i] = 1'b0;
        if (!buf_act[i] && (now - buf_start[i]) > reg_win) begin
          o.removed_count++;
        end else begin
          buf_id[keep] = buf_id[i];
          buf_act[keep] = buf_act[i];
          buf_start[keep] = buf_start[i];
          buf_end[keep] = buf_end[i];
          keep++;
        end
      end
      buf_count = keep;
    end else if (kind == teb_pkg::KIND_CLEAR) begin
      buf_count = 0;
    end
    o.occupancy = 6'(buf_count);
    return o;
  endfunction

  // send one item, queue its outcome
  task automatic send_item(input logic [1:0] kind, input logic [7:0] id, input logic act,
                           input logic [31:0] now, input logic typed, input outcome_t want);
    outcome_t o;
    while ($urandom_range(99) < in_idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_kind <= kind;
    in_event_id <= id;
    in_active_in <= act;
    in_now <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    o = buffer_outcome(kind, id, act, now);
    if (typed && o != want) report_mismatch("directed outcome", int'(o), int'(want));
    pending_outcomes.push_back(o);
    n_items++;
    if (o.evicted) n_evictions++;
    n_removed += o.removed_count;
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait until all outcomes arrived plus settling time
  task automatic drain;
    int guard;
    guard = 0;
    while (pending_outcomes.size() != 0 && guard < IDLE_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (2 * DEPTH + 8) @(posedge clk);
  endtask

  // register write, block idle
  task automatic write_reg(input teb_pkg::cfg_idx_t idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      teb_pkg::CFG_CAPACITY: reg_cap = data[5:0];
      teb_pkg::CFG_INTERVAL: reg_intv = data;
      default:               reg_win = data;
    endcase
    @(posedge clk);
  endtask

  // result checker and receiver stall
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_outcomes.size() == 0) begin
        errors++;
        $display("error: result with nothing expected");
      end else begin
        want = pending_outcomes.pop_front();
        if (out_updated !== want.updated) report_mismatch("updated", out_updated, want.updated);
        if (out_inserted !== want.inserted)
          report_mismatch("inserted", out_inserted, want.inserted);
        if (out_evicted !== want.evicted) report_mismatch("evicted", out_evicted, want.evicted);
        if (out_evicted_id !== want.evicted_id)
          report_mismatch("evicted_id", out_evicted_id, want.evicted_id);
        if (out_removed_count !== want.removed_count)
          report_mismatch("removed_count", out_removed_count, want.removed_count);
        if (out_occupancy !== want.occupancy)
          report_mismatch("occupancy", out_occupancy, want.occupancy);
      end
      n_results++;
    end
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  // watchdog on accepted handshakes
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout");
      $display("timed_event_buffer: mismatch");
      $finish;
    end
  end

  // random item, mostly events on a small id pool with advancing time
  logic [31:0] clock_ms;
  task automatic random_item;
    int r;
    logic [7:0] id;
    r = $urandom_range(99);
    clock_ms = clock_ms + $urandom_range(60);
    if ($urandom_range(49) == 0) clock_ms = clock_ms + $urandom;
    id = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(12));
    if (r < 70)
      send_item(teb_pkg::KIND_EVENT, id, 1'($urandom), clock_ms, 1'b0, '0);
    else if (r < 95)
      send_item(teb_pkg::KIND_TICK, 8'($urandom), 1'($urandom), clock_ms, 1'b0, '0);
    else if (r < 98)
      send_item(teb_pkg::KIND_CLEAR, 8'($urandom), 1'($urandom), $urandom, 1'b0, '0);
    else
      send_item(2'd3, 8'($urandom), 1'($urandom), $urandom, 1'b0, '0);
  endtask

  // directed stimulus table
  row_t dir_rows[] = '{
    '{2'd0, 8'h00, 1'b1, 32'd0,          1'b1, '{0, 1, 0, 8'h00, 6'd0, 6'd1}},
    '{2'd0, 8'h00, 1'b0, 32'd10,         1'b1, '{1, 0, 0, 8'h00, 6'd0, 6'd1}},
    '{2'd0, 8'h00, 1'b1, 32'd20,         1'b1, '{0, 1, 0, 8'h00, 6'd0, 6'd2}},
    '{2'd0, 8'hFF, 1'b1, 32'hFFFF_FFFF,  1'b1, '{0, 1, 0, 8'h00, 6'd0, 6'd3}},
    '{2'd3, 8'hAA, 1'b1, 32'd5,          1'b1, '{0, 0, 0, 8'h00, 6'd0, 6'd3}},
    '{2'd1, 8'h00, 1'b0, 32'd100,        1'b0, '0},
    '{2'd1, 8'h00, 1'b0, 32'd121,        1'b0, '0},
    '{2'd1, 8'h00, 1'b0, 32'd520,        1'b0, '0},
    '{2'd1, 8'h00, 1'b0, 32'd521,        1'b0, '0},
    '{2'd0, 8'h55, 1'b1, 32'hFFFF_FFF0,  1'b0, '0},
    '{2'd1, 8'h00, 1'b0, 32'd80,         1'b0, '0},
    '{2'd1, 8'h00, 1'b0, 32'd600,        1'b0, '0},
    '{2'd2, 8'h12, 1'b1, 32'd0,          1'b1, '{0, 0, 0, 8'h00, 6'd0, 6'd0}},
    '{2'd1, 8'h00, 1'b1, 32'hFFFF_FFFF,  1'b1, '{0, 0, 0, 8'h00, 6'd0, 6'd0}}
  };

  initial begin
    int phase;
    clock_ms = '0;
    reg_cap = teb_pkg::CAP_RST;
    reg_intv = teb_pkg::INTV_RST;
    reg_win = teb_pkg::WIN_RST;
    buf_count = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows at reset register values
    foreach (dir_rows[k])
      send_item(dir_rows[k].kind, dir_rows[k].event_id, dir_rows[k].active_in,
                dir_rows[k].now, dir_rows[k].typed, dir_rows[k].want);
    drain();

    // fill to capacity 2: evictions of the first inactive entry, or of the oldest when none is inactive
    write_reg(teb_pkg::CFG_CAPACITY, 32'd2);
    write_reg(teb_pkg::CFG_INTERVAL, 32'd0);
    write_reg(teb_pkg::CFG_WINDOW, 32'hFFFF_FFFF);
    for (int k = 0; k < 6; k++)
      send_item(teb_pkg::KIND_EVENT, 8'(k + 1), 1'(k % 2), 32'(k * 3), 1'b0, '0);
    drain();
    // capacity 0 means full depth: fill past it, then lower capacity below occupancy
    write_reg(teb_pkg::CFG_CAPACITY, 32'd0);
    for (int k = 0; k < 34; k++)
      send_item(teb_pkg::KIND_EVENT, 8'(k + 40), 1'b1, 32'(k), 1'b0, '0);
    drain();
    write_reg(teb_pkg::CFG_CAPACITY, 32'd1);
    send_item(teb_pkg::KIND_EVENT, 8'd200, 1'b1, 32'd90, 1'b0, '0);
    send_item(teb_pkg::KIND_TICK, 8'd0, 1'b0, 32'd95, 1'b0, '0);
    drain();

    // random phases with varying registers and idling
    for (phase = 0; phase < 6; phase++) begin
      in_idle_pct = (phase < 2) ? 38 : (phase < 4) ? 70 : 0;
      out_idle_pct = (phase < 2) ? 70 : (phase < 4) ? 38 : 0;
      case (phase)
        0: write_reg(teb_pkg::CFG_CAPACITY, 32'd20);
        1: write_reg(teb_pkg::CFG_CAPACITY, 32'd32);
        2: write_reg(teb_pkg::CFG_CAPACITY, 32'd63);
        3: write_reg(teb_pkg::CFG_CAPACITY, 32'd3);
        4: write_reg(teb_pkg::CFG_CAPACITY, 32'd8);
        default: write_reg(teb_pkg::CFG_CAPACITY, 32'd0);
      endcase
      write_reg(teb_pkg::CFG_INTERVAL,
                (phase == 5) ? 32'hFFFF_FFFF : 32'($urandom_range(150)));
      write_reg(teb_pkg::CFG_WINDOW, (phase == 4) ? 32'd0 : 32'($urandom_range(900)));
      for (int k = 0; k < N_RANDOM / 6; k++) begin
        random_item();
        // sender holds off until every result is back
        if (k == 100) begin
          while (pending_outcomes.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    $display("covered %0d items and %0d results, %0d evictions, %0d sweep removals",
             n_items, n_results, n_evictions, n_removed);
    if (errors == 0 && pending_outcomes.size() == 0) begin
      $display("timed_event_buffer: match");
    end else begin
      $display("timed_event_buffer: mismatch");
    end
    $finish;
  end

endmodule
